>>> rtl/fdr_pkg.sv
// Shared widths, per-channel state record and reset constants of the fader.
package fdr_pkg;

	localparam int unsigned LEVEL_W  = 14;
	localparam int unsigned RISE_W   = 16;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned MAG_W    = 8;
	localparam int unsigned CHANNELS = 3;
	localparam int unsigned CH_W     = 2;

	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [RISE_W-1:0]   rise_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [MAG_W-1:0]    mag_t;

	localparam level_t LEVEL_AT_RESET = LEVEL_W'(10);
	localparam rise_t  RISE_AT_RESET  = RISE_W'(1);
	localparam mag_t   STEP_LIMIT     = MAG_W'(255);

	// One channel's ramp state; mag of zero means the channel is idle
	typedef struct packed {
		level_t  level;
		level_t  goal;
		period_t period;
		logic    neg;
		mag_t    mag;
		period_t countdown;
	} fdr_entry_t;

	localparam fdr_entry_t ENTRY_RESET = '{
		level:     LEVEL_AT_RESET,
		goal:      LEVEL_AT_RESET,
		period:    '0,
		neg:       1'b0,
		mag:       '0,
		countdown: '0
	};

endpackage

>>> rtl/fdr_item_if.sv
// Input item channel: action and the three new targets.
interface fdr_item_if import fdr_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   action;
	level_t red_target;
	level_t green_target;
	level_t blue_target;

	modport source (output valid, action, red_target, green_target, blue_target, input ready);
	modport sink   (input valid, action, red_target, green_target, blue_target, output ready);
endinterface

>>> rtl/fdr_result_if.sv
// Result channel: the three current levels and the ramp activity mask.
interface fdr_result_if import fdr_pkg::*; ();
	logic                valid;
	logic                ready;
	level_t              red_level;
	level_t              green_level;
	level_t              blue_level;
	logic [CHANNELS-1:0] ramping_mask;

	modport source (output valid, red_level, green_level, blue_level, ramping_mask, input ready);
	modport sink   (input valid, red_level, green_level, blue_level, ramping_mask, output ready);
endinterface

>>> rtl/fdr_cfg_if.sv
// Configuration write channel carrying the rise time register.
interface fdr_cfg_if import fdr_pkg::*; ();
	logic  valid;
	logic  ready;
	rise_t rise_seconds;

	modport source (output valid, rise_seconds, input ready);
	modport sink   (input valid, rise_seconds, output ready);
endinterface

>>> rtl/fdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/fdr_div.sv
// Restoring divider, one quotient bit per cycle.
module fdr_div #(
	parameter int unsigned NUM_W = 30,
	parameter int unsigned DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/three_channel_linear_fader.sv
// Three-channel linear brightness fader: sequencer, state RAM and shared divider.
// Tick transaction: per channel a RAM read, then update and write back; the result is
//   registered once the output register is free, and only then is the next item taken.
// Load transaction: per channel the shared bit-serial divider computes the base and, when
//   the base is at most ticks per ms, the step; a target equal to the current level skips it.
// Reset: rise time 1 s, every channel at level 10 and idle. The state RAM is not cleared;
//   a valid bit per channel makes an unwritten entry read as its reset value.
module three_channel_linear_fader import fdr_pkg::*; #(
	parameter int unsigned TICKS_PER_SEC = 10000,
	parameter int unsigned TICKS_PER_MS  = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	fdr_cfg_if.sink      cfg,
	fdr_item_if.sink     item,
	fdr_result_if.source result
);

	// Width of the numerator of the first division: tick rate times rise seconds
	localparam int unsigned PROD_W  = $clog2(TICKS_PER_SEC) + RISE_W;
	localparam int unsigned QEXT_W  = (PROD_W > PERIOD_W) ? PROD_W : PERIOD_W + 1;
	localparam int unsigned ENTRY_W = $bits(fdr_entry_t);
	localparam int unsigned MULT_W  = PERIOD_W + MAG_W;

	localparam logic [PROD_W-1:0] TPS_P   = PROD_W'(TICKS_PER_SEC);
	localparam logic [PROD_W-1:0] TPM_P   = PROD_W'(TICKS_PER_MS);
	localparam period_t           TPM_B   = PERIOD_W'(TICKS_PER_MS);
	localparam logic [CH_W-1:0]   LAST_CH = CH_W'(CHANNELS - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;  // RAM read issued
	localparam logic [2:0] ST_EVAL = 3'd2;  // entry back: tick update or load set-up
	localparam logic [2:0] ST_DIV1 = 3'd3;  // base = scaled rise / distance
	localparam logic [2:0] ST_DIV2 = 3'd4;  // step = ticks per ms / base, plus one, capped at 255
	localparam logic [2:0] ST_FIN  = 3'd5;  // period = base * step, write back
	localparam logic [2:0] ST_DONE = 3'd6;  // hand result to output register

	logic [2:0]          state_q;
	logic [CH_W-1:0]     ch_q;
	logic                action_q;
	level_t              tgt_q [CHANNELS];
	rise_t               rise_q;
	logic [CHANNELS-1:0] valid_q;
	fdr_entry_t          ent_q;
	logic                up_q;
	period_t             base_q;
	mag_t                step_q;
	level_t              res_lev_q [CHANNELS];
	logic [CHANNELS-1:0] res_act_q;
	logic                out_valid_q;
	level_t              out_lev_q [CHANNELS];
	logic [CHANNELS-1:0] out_mask_q;

	logic [ENTRY_W-1:0] ram_rdata;
	logic               ram_re;
	logic               wr_en;
	fdr_entry_t         wr_entry;
	fdr_entry_t         rd_entry;

	logic              div_start;
	logic [PROD_W-1:0] div_num;
	logic [LEVEL_W-1:0] div_den;
	logic              div_done;
	logic [PROD_W-1:0] div_quo;

	level_t            tgt_cur;
	logic              up;
	logic              same;
	level_t            distance;
	logic [PROD_W-1:0] scaled;
	logic [QEXT_W-1:0] quo_ext;
	period_t           base_new;
	logic [MULT_W-1:0] prod;
	period_t           period;
	logic              item_acc;
	logic              out_load;

	// One tick on a channel, then the clamp at the goal
	function automatic fdr_entry_t tick_entry(fdr_entry_t e);
		fdr_entry_t              r;
		logic signed [LEVEL_W+1:0] lv;
		logic signed [LEVEL_W+1:0] gl;
		logic signed [LEVEL_W+1:0] st;
		logic                    reached;
		r  = e;
		lv = signed'((LEVEL_W+2)'(e.level));
		gl = signed'((LEVEL_W+2)'(e.goal));
		st = signed'((LEVEL_W+2)'(e.mag));
		if (e.mag != '0) begin
			if (e.countdown > PERIOD_W'(1)) begin
				r.countdown = e.countdown - PERIOD_W'(1);
			end else begin
				lv          = e.neg ? (lv - st) : (lv + st);
				r.countdown = e.period;
			end
			reached = e.neg ? (lv <= gl) : (lv >= gl);
			if (reached) begin
				r.mag       = '0;
				r.neg       = 1'b0;
				r.level     = e.goal;
				r.countdown = '0;
			end else begin
				r.level = lv[LEVEL_W-1:0];
			end
		end
		return r;
	endfunction

	assign item_acc  = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

	// Unwritten entries read as reset state
	assign rd_entry = valid_q[ch_q] ? fdr_entry_t'(ram_rdata) : ENTRY_RESET;

	assign tgt_cur  = tgt_q[ch_q];
	assign up       = tgt_cur > rd_entry.level;
	assign same     = tgt_cur == rd_entry.level;
	assign distance = up ? (tgt_cur - rd_entry.level) : (rd_entry.level - tgt_cur);
	assign scaled   = TPS_P * PROD_W'(rise_q);

	// Base saturates at 32 bits; zero is raised to one
	assign quo_ext = QEXT_W'(div_quo);
	always_comb begin
		base_new = (|quo_ext[QEXT_W-1:PERIOD_W]) ? '1 : quo_ext[PERIOD_W-1:0];
		if (base_new == '0) begin
			base_new = PERIOD_W'(1);
		end
	end

	// Step above one only with base at most ticks per ms, so no overflow here
	assign prod   = MULT_W'(base_q) * MULT_W'(step_q);
	assign period = prod[PERIOD_W-1:0];

	assign ram_re = (state_q == ST_RD);

	always_comb begin
		wr_en     = 1'b0;
		wr_entry  = rd_entry;
		div_start = 1'b0;
		div_num   = scaled;
		div_den   = distance;
		case (state_q)
			ST_EVAL: begin
				if (!action_q) begin
					wr_en    = 1'b1;
					wr_entry = tick_entry(rd_entry);
				end else if (same) begin
					// target already met: stop the ramp, goal left as it was
					wr_en              = 1'b1;
					wr_entry.period    = '0;
					wr_entry.mag       = '0;
					wr_entry.neg       = 1'b0;
					wr_entry.countdown = '0;
				end else begin
					div_start = 1'b1;
				end
			end
			ST_DIV1: begin
				if (div_done && (base_new <= TPM_B)) begin
					div_start = 1'b1;
					div_num   = TPM_P;
					div_den   = base_new[LEVEL_W-1:0];
				end
			end
			ST_FIN: begin
				wr_en              = 1'b1;
				wr_entry           = ent_q;
				wr_entry.goal      = tgt_cur;
				wr_entry.period    = period;
				wr_entry.mag       = step_q;
				wr_entry.neg       = !up_q;
				wr_entry.countdown = period;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			action_q    <= 1'b0;
			rise_q      <= RISE_AT_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				rise_q <= cfg.rise_seconds;
			end
			if (wr_en) begin
				valid_q[ch_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						action_q <= item.action;
						ch_q     <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (action_q && !same) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= (base_new <= TPM_B) ? ST_DIV2 : ST_FIN;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// always writes back; next state set below
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// channel written back: move on or finish
			if (wr_en) begin
				if (ch_q == LAST_CH) begin
					state_q <= ST_DONE;
				end else begin
					ch_q    <= ch_q + CH_W'(1);
					state_q <= ST_RD;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			tgt_q[0] <= item.red_target;
			tgt_q[1] <= item.green_target;
			tgt_q[2] <= item.blue_target;
		end
		if (state_q == ST_EVAL) begin
			ent_q <= rd_entry;
			up_q  <= up;
		end
		if (state_q == ST_DIV1 && div_done) begin
			base_q <= base_new;
			step_q <= MAG_W'(1);
		end
		if (state_q == ST_DIV2 && div_done) begin
			if (div_quo >= PROD_W'(STEP_LIMIT)) begin
				step_q <= STEP_LIMIT;
			end else begin
				step_q <= div_quo[MAG_W-1:0] + MAG_W'(1);
			end
		end
		if (wr_en) begin
			res_lev_q[ch_q] <= wr_entry.level;
			res_act_q[ch_q] <= (wr_entry.mag != '0);
		end
		if (out_load) begin
			out_lev_q  <= res_lev_q;
			out_mask_q <= res_act_q;
		end
	end

	fdr_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ch_q),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ch_q),
		.rdata (ram_rdata)
	);

	fdr_div #(
		.NUM_W (PROD_W),
		.DEN_W (LEVEL_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign result.valid        = out_valid_q;
	assign result.red_level    = out_lev_q[0];
	assign result.green_level  = out_lev_q[1];
	assign result.blue_level   = out_lev_q[2];
	assign result.ramping_mask = out_mask_q;

	// Divider completions only arrive while the sequencer waits for them
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider completion outside a divide state");

	// A taken transaction starts with the first channel's RAM read
	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> (state_q == ST_RD && ch_q == '0))
		else $error("accepted transaction did not start at the first channel");

	// Handing over the result always leaves a valid output register
	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (result.valid && state_q == ST_IDLE))
		else $error("result not presented after completion");

endmodule
